FILE: src/mfir_pkg.sv
// ----------------------------------------------------------------------------
// mfir_pkg
// Shared types, constants and fixed-point helpers of the fisheye IPM remapper.
// ----------------------------------------------------------------------------
package mfir_pkg;

  localparam int MAX_CAMERAS   = 4;
  localparam int FRAC_BITS     = 20;
  localparam int COORD_BITS    = 12;
  localparam int WORDS_PER_CAM = 22;
  localparam int MAX_RESULTS   = 4;
  localparam int CAM_CAP       = (MAX_CAMERAS < MAX_RESULTS) ? MAX_CAMERAS : MAX_RESULTS;
  localparam int TBL_DEPTH     = MAX_CAMERAS * WORDS_PER_CAM;
  localparam int TBL_AW        = $clog2(TBL_DEPTH);
  localparam int ACC_W         = 66 - FRAC_BITS;
  localparam int PIX_W         = 64 - 2 * FRAC_BITS;
  localparam int CMP_W         = (PIX_W > 17) ? PIX_W : 17;
  localparam int DIV_NUM_W     = 32 + FRAC_BITS;
  localparam int DIV_STEPS     = 31;
  localparam int ZMIN          = (1 << FRAC_BITS) / 1000000;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;
  localparam logic signed [63:0] RND_F  = (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam logic signed [63:0] RND_2F = (64'sd1 <<< (2 * FRAC_BITS)) - 64'sd1;
  localparam logic signed [65:0] ONE_W  = 66'sd1 <<< FRAC_BITS;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_PROJECT = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_VIEW_WIDTH     = 2'd0,
    CFG_VIEW_HEIGHT    = 2'd1,
    CFG_GROUND_SCALE   = 2'd2,
    CFG_ACTIVE_CAMERAS = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    W_T0 = 5'd9,  W_T1 = 5'd10, W_T2 = 5'd11, W_XI = 5'd12,
    W_K1 = 5'd13, W_K2 = 5'd14, W_P1 = 5'd15, W_P2 = 5'd16,
    W_FX = 5'd17, W_FY = 5'd18, W_CX = 5'd19, W_CY = 5'd20,
    W_SIZE = 5'd21
  } word_e;

  typedef struct packed {
    logic               opcode;
    logic [1:0]         cam_select;
    logic [4:0]         word_index;
    logic signed [31:0] word_value;
    logic [11:0]        view_u;
    logic [11:0]        view_v;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            cam_index;
    logic [COORD_BITS-1:0] source_x;
    logic [COORD_BITS-1:0] source_y;
    logic                  hit;
    logic                  near_axis;
    logic                  last_camera;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] tdiv_f(input logic signed [63:0] p);
    return (p + (p[63] ? RND_F : 64'sd0)) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] fmul_post(input logic signed [63:0] p);
    return sat32(66'(tdiv_f(p)));
  endfunction

  function automatic logic signed [PIX_W-1:0] pix_trunc(input logic signed [63:0] s);
    logic signed [63:0] t;
    t = (s + (s[63] ? RND_2F : 64'sd0)) >>> (2 * FRAC_BITS);
    return t[PIX_W-1:0];
  endfunction

endpackage

FILE: src/mfir_in_if.sv
// ----------------------------------------------------------------------------
// mfir_in_if
// Valid/ready channel carrying load and project transactions.
// ----------------------------------------------------------------------------
interface mfir_in_if import mfir_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/mfir_out_if.sv
// ----------------------------------------------------------------------------
// mfir_out_if
// Valid/ready channel carrying per-camera result transactions.
// ----------------------------------------------------------------------------
interface mfir_out_if import mfir_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/mfir_div.sv
// ----------------------------------------------------------------------------
// mfir_div
// Bit-serial signed fixed-point divider: sat32(num * 2^F / den), truncating.
// ----------------------------------------------------------------------------
module mfir_div import mfir_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  logic                   busy_q;
  logic                   done_q;
  logic [4:0]             cnt_q;
  logic [31:0]            rem_q;
  logic [30:0]            sh_q;
  logic [30:0]            mag_q;
  logic [31:0]            den_q;
  logic                   neg_q;
  logic signed [31:0]     quo_q;

  logic [31:0]            n_abs;
  logic [31:0]            d_abs;
  logic [DIV_NUM_W-1:0]   num_mag;
  logic [31:0]            num_hi;
  logic [32:0]            trial;
  logic                   take;
  logic [30:0]            mag_d;

  always_comb begin
    n_abs   = num_i[31] ? (~num_i + 32'd1) : num_i;
    d_abs   = den_i[31] ? (~den_i + 32'd1) : den_i;
    num_mag = {n_abs, {FRAC_BITS{1'b0}}};
    num_hi  = 32'(num_mag[DIV_NUM_W-1:31]);
    trial   = {rem_q, sh_q[30]};
    take    = trial >= {1'b0, den_q};
    mag_d   = {mag_q[29:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        neg_q <= num_i[31] ^ den_i[31];
        den_q <= d_abs;
        if (num_hi >= d_abs) begin
          quo_q  <= (num_i[31] ^ den_i[31]) ? 32'sh80000000 : 32'sh7fffffff;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          rem_q  <= num_hi;
          sh_q   <= num_mag[30:0];
          mag_q  <= '0;
          cnt_q  <= 5'(DIV_STEPS);
        end
      end else if (busy_q) begin
        if (take) begin
          rem_q <= 32'(trial - {1'b0, den_q});
        end else begin
          rem_q <= trial[31:0];
        end
        sh_q  <= {sh_q[29:0], 1'b0};
        mag_q <= mag_d;
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          quo_q  <= neg_q ? -$signed({1'b0, mag_d}) : $signed({1'b0, mag_d});
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: src/mfir_sqrt.sv
// ----------------------------------------------------------------------------
// mfir_sqrt
// Digit-by-digit integer square root of a 64-bit radicand, two bits a cycle.
// ----------------------------------------------------------------------------
module mfir_sqrt import mfir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [63:0] rad_q;
  logic [34:0] rem_q;
  logic [31:0] root_q;

  logic [34:0] rem_n;
  logic [34:0] trial;
  logic        take;

  always_comb begin
    rem_n = {rem_q[32:0], rad_q[63:62]};
    trial = {1'b0, root_q, 2'b01};
    take  = rem_n >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        rad_q  <= rad_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        rad_q <= {rad_q[61:0], 2'b00};
        if (take) begin
          rem_q  <= rem_n - trial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem_n;
          root_q <= {root_q[30:0], 1'b0};
        end
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: src/mei_fisheye_ipm_remap.sv
// ----------------------------------------------------------------------------
// mei_fisheye_ipm_remap
// Bird's-eye to fisheye remapper: sequencer around one shared 32x32 multiplier,
// a bit-serial divider and a bit-serial square root.
// ----------------------------------------------------------------------------
// Load transaction: accepted while idle, no result.
// Project transaction: ground-coordinate setup, then per camera a square root,
//   two divisions and the multiplier steps; a point behind a camera skips
//   them and leaves with no hit.
// Not ready while a pixel is in work; results leave through an output register.
// Reset restores register defaults; the camera table is undefined until written.
// ----------------------------------------------------------------------------
module mei_fisheye_ipm_remap import mfir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  mfir_in_if.sink     in_i,
  mfir_out_if.source  out_o
);

  typedef enum logic [5:0] {
    S_IDLE, S_GX, S_GY, S_GEND, S_CAM, S_T1, S_T2, S_R0, S_MA, S_MB,
    S_Z, S_SQ1, S_SQ2, S_SQ3, S_SQW, S_XI, S_DEN, S_DEN2, S_DXW, S_DYW,
    S_E0, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7, S_E8, S_E9, S_E10,
    S_E11, S_E12, S_G0, S_G1, S_G2, S_G3, S_G4, S_EMIT
  } state_e;

  state_e                  state_q;
  logic [12:0]             width_q;
  logic [12:0]             height_q;
  logic [30:0]             scale_q;
  logic [2:0]              active_q;

  logic signed [31:0]      table_q [TBL_DEPTH];
  logic signed [31:0]      rd_q;

  logic [11:0]             u_q;
  logic [11:0]             v_q;
  logic [2:0]              n_q;
  logic [1:0]              cam_q;
  logic [1:0]              k_q;
  logic [1:0]              i_q;
  logic signed [31:0]      gx_q;
  logic signed [31:0]      gy_q;
  logic signed [31:0]      d_q [3];
  logic signed [31:0]      c_q [3];
  logic signed [ACC_W-1:0] acc_q;
  logic [63:0]             sxy_q;
  logic signed [31:0]      p_q;
  logic signed [31:0]      den_q;
  logic signed [31:0]      x3_q;
  logic signed [31:0]      y3_q;
  logic signed [31:0]      xx_q;
  logic signed [31:0]      yy_q;
  logic signed [31:0]      r2_q;
  logic signed [31:0]      xy_q;
  logic signed [31:0]      r4_q;
  logic signed [31:0]      k1r2_q;
  logic signed [31:0]      radial_q;
  logic signed [31:0]      ta_q;
  logic signed [31:0]      tb_q;
  logic signed [31:0]      xt_q;
  logic signed [31:0]      yt_q;
  logic signed [31:0]      xd_q;
  logic signed [31:0]      yd_q;
  logic signed [PIX_W-1:0] px_q;
  logic signed [PIX_W-1:0] py_q;
  logic                    res_hit_q;
  logic                    res_near_q;
  logic [COORD_BITS-1:0]   res_x_q;
  logic [COORD_BITS-1:0]   res_y_q;
  logic signed [63:0]      prod_q;

  logic                    out_valid_q;
  out_item_t               out_q;

  logic signed [31:0]      mul_a;
  logic signed [31:0]      mul_b;
  logic [4:0]              rd_word;
  logic [TBL_AW-1:0]       rd_addr;
  logic [TBL_AW-1:0]       wr_addr;
  logic                    wr_en;
  logic                    in_fire;
  logic signed [14:0]      gxa;
  logic signed [14:0]      gya;
  logic [1:0]              nk;
  logic [1:0]              ni;
  logic signed [31:0]      fp;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [63:0]      pix_sum;
  logic [2:0]              n_cap;
  logic                    out_free;
  logic                    last_cam;
  logic                    emit_fire;

  logic                    sq_start;
  logic                    sq_done;
  logic [31:0]             sq_root;
  logic                    div_start;
  logic                    div_done;
  logic signed [31:0]      div_num;
  logic signed [31:0]      div_quo;

  logic [15:0]             img_w;
  logic [15:0]             img_h;
  logic [CMP_W-1:0]        px_e;
  logic [CMP_W-1:0]        py_e;
  logic                    in_img;

  localparam logic [CMP_W-1:0] LIM = CMP_W'(1) << COORD_BITS;

  assign in_fire   = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign emit_fire = (state_q == S_EMIT) && out_free;
  assign last_cam  = (3'(cam_q) + 3'd1) == n_q;
  assign fp        = fmul_post(prod_q);

  always_comb begin
    gxa     = $signed({2'b00, u_q, 1'b0}) - $signed({2'b00, height_q});
    gya     = $signed({2'b00, width_q}) - $signed({2'b00, v_q, 1'b0});
    nk      = (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
    ni      = (k_q == 2'd2) ? i_q + 2'd1 : i_q;
    acc_sum = acc_q + ACC_W'(tdiv_f(prod_q));
    pix_sum = prod_q + (64'(rd_q) <<< FRAC_BITS);
    n_cap   = (32'(active_q) > CAM_CAP) ? 3'(CAM_CAP) : active_q;
    wr_addr = TBL_AW'(in_i.payload.cam_select) * TBL_AW'(WORDS_PER_CAM)
              + TBL_AW'(in_i.payload.word_index);
    wr_en   = in_fire && (in_i.payload.opcode == OP_LOAD)
              && (32'(in_i.payload.cam_select) < MAX_CAMERAS)
              && (32'(in_i.payload.word_index) < WORDS_PER_CAM);
    rd_addr = TBL_AW'(cam_q) * TBL_AW'(WORDS_PER_CAM) + TBL_AW'(rd_word);
    img_w   = rd_q[31:16];
    img_h   = rd_q[15:0];
    px_e    = CMP_W'(unsigned'(px_q));
    py_e    = CMP_W'(unsigned'(py_q));
    in_img  = !px_q[PIX_W-1] && !py_q[PIX_W-1]
              && (px_e < CMP_W'(img_w)) && (py_e < CMP_W'(img_h))
              && (px_e < LIM) && (py_e < LIM);
  end

  always_comb begin
    rd_word = 5'd0;
    unique case (state_q)
      S_CAM:               rd_word = W_T0;
      S_T1:                rd_word = W_T1;
      S_T2:                rd_word = W_T2;
      S_R0:                rd_word = 5'd0;
      S_MB:                rd_word = 5'({nk, 1'b0}) + 5'(nk) + 5'(ni);
      S_SQ3, S_SQW:        rd_word = W_XI;
      S_E3:                rd_word = W_K1;
      S_E4:                rd_word = W_K2;
      S_E5, S_E6:          rd_word = W_P1;
      S_E7, S_E8:          rd_word = W_P2;
      S_E12:               rd_word = W_FX;
      S_G0:                rd_word = W_CX;
      S_G1:                rd_word = W_FY;
      S_G2:                rd_word = W_CY;
      S_G3:                rd_word = W_SIZE;
      default:             rd_word = 5'd0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_GX:  begin mul_a = 32'(gxa);  mul_b = $signed({1'b0, scale_q}); end
      S_GY:  begin mul_a = 32'(gya);  mul_b = $signed({1'b0, scale_q}); end
      S_MA:  begin mul_a = rd_q;      mul_b = d_q[k_q];  end
      S_Z:   begin mul_a = c_q[0];    mul_b = c_q[0];    end
      S_SQ1: begin mul_a = c_q[1];    mul_b = c_q[1];    end
      S_SQ2: begin mul_a = c_q[2];    mul_b = c_q[2];    end
      S_XI:  begin mul_a = rd_q;      mul_b = p_q;       end
      S_E0:  begin mul_a = x3_q;      mul_b = x3_q;      end
      S_E1:  begin mul_a = y3_q;      mul_b = y3_q;      end
      S_E2:  begin mul_a = x3_q;      mul_b = y3_q;      end
      S_E3:  begin mul_a = r2_q;      mul_b = r2_q;      end
      S_E4:  begin mul_a = rd_q;      mul_b = r2_q;      end
      S_E5:  begin mul_a = rd_q;      mul_b = r4_q;      end
      S_E6:  begin mul_a = rd_q;      mul_b = xy_q;      end
      S_E7:  begin
        mul_a = rd_q;
        mul_b = sat32(66'(r2_q) + (66'(yy_q) <<< 1));
      end
      S_E8:  begin
        mul_a = rd_q;
        mul_b = sat32(66'(r2_q) + (66'(xx_q) <<< 1));
      end
      S_E9:  begin mul_a = rd_q;      mul_b = xy_q;      end
      S_E10: begin mul_a = x3_q;      mul_b = radial_q;  end
      S_E11: begin mul_a = y3_q;      mul_b = radial_q;  end
      S_G0:  begin mul_a = rd_q;      mul_b = xd_q;      end
      S_G2:  begin mul_a = rd_q;      mul_b = yd_q;      end
      default: begin mul_a = '0;      mul_b = '0;        end
    endcase
  end

  assign sq_start  = (state_q == S_SQ3);
  assign div_start = ((state_q == S_DEN2) && (den_q != 32'sd0))
                     || ((state_q == S_DXW) && div_done);
  assign div_num   = (state_q == S_DEN2) ? c_q[0] : c_q[1];

  mfir_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sxy_q + unsigned'(prod_q)),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  mfir_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_q[wr_addr] <= in_i.payload.word_value;
    end
    rd_q   <= table_q[rd_addr];
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1024;
      height_q <= 13'd1024;
      scale_q  <= 31'd20972;
      active_q <= 3'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VIEW_WIDTH:     width_q  <= cfg_data_i[12:0];
        CFG_VIEW_HEIGHT:    height_q <= cfg_data_i[12:0];
        CFG_GROUND_SCALE:   scale_q  <= cfg_data_i;
        CFG_ACTIVE_CAMERAS: active_q <= cfg_data_i[2:0];
        default:            active_q <= active_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cam_q       <= '0;
      n_q         <= '0;
      k_q         <= '0;
      i_q         <= '0;
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && (in_i.payload.opcode == OP_PROJECT)) begin
            u_q <= in_i.payload.view_u;
            v_q <= in_i.payload.view_v;
            n_q <= n_cap;
            if (n_cap != 3'd0) begin
              state_q <= S_GX;
            end
          end
        end
        S_GX:   state_q <= S_GY;
        S_GY: begin
          gx_q    <= sat32((66'(prod_q) + (prod_q[63] ? 66'sd1 : 66'sd0)) >>> 1);
          state_q <= S_GEND;
        end
        S_GEND: begin
          gy_q    <= sat32((66'(prod_q) + (prod_q[63] ? 66'sd1 : 66'sd0)) >>> 1);
          cam_q   <= '0;
          state_q <= S_CAM;
        end
        S_CAM:  state_q <= S_T1;
        S_T1: begin
          d_q[0]  <= sat32(66'(gx_q) - 66'(rd_q));
          state_q <= S_T2;
        end
        S_T2: begin
          d_q[1]  <= sat32(66'(gy_q) - 66'(rd_q));
          state_q <= S_R0;
        end
        S_R0: begin
          d_q[2]  <= sat32(-66'(rd_q));
          k_q     <= '0;
          i_q     <= '0;
          acc_q   <= '0;
          state_q <= S_MA;
        end
        S_MA:   state_q <= S_MB;
        S_MB: begin
          k_q <= nk;
          i_q <= ni;
          if (k_q == 2'd2) begin
            c_q[i_q] <= sat32(66'(acc_sum));
            acc_q    <= '0;
            state_q  <= (i_q == 2'd2) ? S_Z : S_MA;
          end else begin
            acc_q   <= acc_sum;
            state_q <= S_MA;
          end
        end
        S_Z: begin
          if (c_q[2] <= 32'(ZMIN)) begin
            res_hit_q  <= 1'b0;
            res_near_q <= 1'b0;
            res_x_q    <= '0;
            res_y_q    <= '0;
            state_q    <= S_EMIT;
          end else begin
            state_q <= S_SQ1;
          end
        end
        S_SQ1: begin
          sxy_q   <= unsigned'(prod_q);
          state_q <= S_SQ2;
        end
        S_SQ2: begin
          sxy_q   <= sxy_q + unsigned'(prod_q);
          state_q <= S_SQ3;
        end
        S_SQ3: begin
          res_near_q <= sxy_q <= unsigned'(prod_q);
          state_q    <= S_SQW;
        end
        S_SQW: begin
          if (sq_done) begin
            p_q     <= sq_root[31] ? 32'sh7fffffff : $signed(sq_root);
            state_q <= S_XI;
          end
        end
        S_XI:   state_q <= S_DEN;
        S_DEN: begin
          den_q   <= sat32(66'(c_q[2]) + 66'(fp));
          state_q <= S_DEN2;
        end
        S_DEN2: begin
          if (den_q == 32'sd0) begin
            res_hit_q <= 1'b0;
            res_x_q   <= '0;
            res_y_q   <= '0;
            state_q   <= S_EMIT;
          end else begin
            state_q <= S_DXW;
          end
        end
        S_DXW: begin
          if (div_done) begin
            x3_q    <= div_quo;
            state_q <= S_DYW;
          end
        end
        S_DYW: begin
          if (div_done) begin
            y3_q    <= div_quo;
            state_q <= S_E0;
          end
        end
        S_E0:   state_q <= S_E1;
        S_E1: begin
          xx_q    <= fp;
          state_q <= S_E2;
        end
        S_E2: begin
          yy_q    <= fp;
          r2_q    <= sat32(66'(xx_q) + 66'(fp));
          state_q <= S_E3;
        end
        S_E3: begin
          xy_q    <= fp;
          state_q <= S_E4;
        end
        S_E4: begin
          r4_q    <= fp;
          state_q <= S_E5;
        end
        S_E5: begin
          k1r2_q  <= fp;
          state_q <= S_E6;
        end
        S_E6: begin
          radial_q <= sat32(ONE_W + 66'(k1r2_q) + 66'(fp));
          state_q  <= S_E7;
        end
        S_E7: begin
          ta_q    <= fp;
          state_q <= S_E8;
        end
        S_E8: begin
          tb_q    <= fp;
          state_q <= S_E9;
        end
        S_E9: begin
          xt_q    <= sat32((66'(ta_q) <<< 1) + 66'(fp));
          state_q <= S_E10;
        end
        S_E10: begin
          yt_q    <= sat32(66'(tb_q) + (66'(fp) <<< 1));
          state_q <= S_E11;
        end
        S_E11: begin
          xd_q    <= sat32(66'(fp) + 66'(xt_q));
          state_q <= S_E12;
        end
        S_E12: begin
          yd_q    <= sat32(66'(fp) + 66'(yt_q));
          state_q <= S_G0;
        end
        S_G0:   state_q <= S_G1;
        S_G1: begin
          px_q    <= pix_trunc(pix_sum);
          state_q <= S_G2;
        end
        S_G2:   state_q <= S_G3;
        S_G3: begin
          py_q    <= pix_trunc(pix_sum);
          state_q <= S_G4;
        end
        S_G4: begin
          res_hit_q <= in_img;
          res_x_q   <= in_img ? px_q[COORD_BITS-1:0] : '0;
          res_y_q   <= in_img ? py_q[COORD_BITS-1:0] : '0;
          state_q   <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_q.cam_index   <= cam_q;
            out_q.source_x    <= res_x_q;
            out_q.source_y    <= res_y_q;
            out_q.hit         <= res_hit_q;
            out_q.near_axis   <= res_near_q;
            out_q.last_camera <= last_cam;
            if (last_cam) begin
              state_q <= S_IDLE;
            end else begin
              cam_q   <= cam_q + 2'd1;
              state_q <= S_CAM;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the fisheye bird's-eye remapper: loads camera tables, projects
// bird's-eye pixels, predicts every per-camera result and checks it in order.
// ----------------------------------------------------------------------------
module tb_top;
  import mfir_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [30:0] cfg_data_i;

  mfir_in_if  in_ch ();
  mfir_out_if out_ch ();

  mei_fisheye_ipm_remap dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  logic signed [31:0] cam_words [TBL_DEPTH];
  logic [12:0]        view_w;
  logic [12:0]        view_h;
  logic [30:0]        scale_q;
  logic [2:0]         cam_count;
  out_item_t          pending_results [$];
  int                 n_errors;
  int                 hold_cycles;
  int                 hold_req;
  int                 hold_seen;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic longint sat_l(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return sat_l((a * b) / (64'sd1 <<< FRAC_BITS));
  endfunction

  function automatic longint word_at(input int cam, input int idx);
    return longint'(cam_words[cam * WORDS_PER_CAM + idx]);
  endfunction

  function automatic longint int_sqrt(input longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic out_item_t map_pixel(input int cam, input longint gx, input longint gy);
    out_item_t o;
    longint d [3];
    longint c [3];
    longint acc, p, den, x3, y3, r2, radial, xy, xt, yt, xd, yd, px, py;
    longint unsigned sxy, szz, iw, ih;
    logic [31:0] sz;
    o = '0;
    o.cam_index = cam[1:0];
    d[0] = sat_l(gx - word_at(cam, W_T0));
    d[1] = sat_l(gy - word_at(cam, W_T1));
    d[2] = sat_l(-word_at(cam, W_T2));
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += (word_at(cam, 3 * k + i) * d[k]) / (64'sd1 <<< FRAC_BITS);
      c[i] = sat_l(acc);
    end
    if (c[2] <= 0 || longint'(c[2]) * 1000000 <= (64'sd1 <<< FRAC_BITS)) return o;
    sxy = longint'(c[0] * c[0]) + longint'(c[1] * c[1]);
    szz = c[2] * c[2];
    o.near_axis = (sxy <= szz);
    p = sat_l(int_sqrt(sxy + szz));
    den = sat_l(c[2] + qmul(word_at(cam, W_XI), p));
    if (den == 0) return o;
    x3 = sat_l((c[0] * (64'sd1 <<< FRAC_BITS)) / den);
    y3 = sat_l((c[1] * (64'sd1 <<< FRAC_BITS)) / den);
    r2 = sat_l(qmul(x3, x3) + qmul(y3, y3));
    radial = sat_l((64'sd1 <<< FRAC_BITS) + qmul(word_at(cam, W_K1), r2)
                   + qmul(word_at(cam, W_K2), qmul(r2, r2)));
    xy = qmul(x3, y3);
    xt = sat_l(2 * qmul(word_at(cam, W_P1), xy)
               + qmul(word_at(cam, W_P2), sat_l(r2 + 2 * qmul(x3, x3))));
    yt = sat_l(qmul(word_at(cam, W_P1), sat_l(r2 + 2 * qmul(y3, y3)))
               + 2 * qmul(word_at(cam, W_P2), xy));
    xd = sat_l(qmul(x3, radial) + xt);
    yd = sat_l(qmul(y3, radial) + yt);
    px = (word_at(cam, W_FX) * xd + word_at(cam, W_CX) * (64'sd1 <<< FRAC_BITS))
         / (64'sd1 <<< (2 * FRAC_BITS));
    py = (word_at(cam, W_FY) * yd + word_at(cam, W_CY) * (64'sd1 <<< FRAC_BITS))
         / (64'sd1 <<< (2 * FRAC_BITS));
    sz = cam_words[cam * WORDS_PER_CAM + W_SIZE];
    iw = sz[31:16];
    ih = sz[15:0];
    if (px < 0 || py < 0) return o;
    if (px >= iw || py >= ih) return o;
    if (px >= (1 << COORD_BITS) || py >= (1 << COORD_BITS)) return o;
    o.source_x = px[11:0];
    o.source_y = py[11:0];
    o.hit = 1'b1;
    return o;
  endfunction

  function automatic void predict_item(input in_item_t it);
    longint gx, gy;
    int n;
    out_item_t o;
    if (it.opcode == OP_LOAD) begin
      if (it.word_index < WORDS_PER_CAM)
        cam_words[it.cam_select * WORDS_PER_CAM + it.word_index] = it.word_value;
      return;
    end
    gx = sat_l(((2 * longint'(it.view_u) - longint'(view_h)) * longint'(scale_q)) / 2);
    gy = sat_l(((longint'(view_w) - 2 * longint'(it.view_v)) * longint'(scale_q)) / 2);
    n = cam_count;
    if (n > CAM_CAP) n = CAM_CAP;
    for (int i = 0; i < n; i++) begin
      o = map_pixel(i, gx, gy);
      o.last_camera = (i + 1 == n);
      pending_results.push_back(o);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    n_errors++;
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_item(it);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [30:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_VIEW_WIDTH:     view_w    = val[12:0];
      CFG_VIEW_HEIGHT:    view_h    = val[12:0];
      CFG_GROUND_SCALE:   scale_q   = val;
      CFG_ACTIVE_CAMERAS: cam_count = val[2:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  task automatic load_word(input int cam, input int idx, input logic signed [31:0] val);
    in_item_t it;
    it = '0;
    it.opcode     = OP_LOAD;
    it.cam_select = cam[1:0];
    it.word_index = idx[4:0];
    it.word_value = val;
    it.view_u     = 12'($urandom);
    it.view_v     = 12'($urandom);
    send_item(it);
  endtask

  task automatic project_px(input logic [11:0] u, input logic [11:0] v);
    in_item_t it;
    it = '0;
    it.opcode     = OP_PROJECT;
    it.cam_select = 2'($urandom);
    it.word_index = 5'($urandom);
    it.word_value = $urandom;
    it.view_u     = u;
    it.view_v     = v;
    send_item(it);
  endtask

  // Cameras look down from ~1.5 m, each yawed by a quarter turn.
  task automatic load_camera(input int cam, input bit noisy);
    logic signed [31:0] w [WORDS_PER_CAM];
    int one;
    one = 1 << FRAC_BITS;
    foreach (w[i]) w[i] = 0;
    case (cam)
      0: begin w[0] = one;  w[4] = -one; w[8] = -one; end
      1: begin w[1] = one;  w[3] = one;  w[8] = -one; end
      2: begin w[0] = -one; w[4] = one;  w[8] = -one; end
      default: begin w[1] = -one; w[3] = -one; w[8] = -one; end
    endcase
    w[W_T0] = $urandom_range(0, 2 * one) - one;
    w[W_T1] = $urandom_range(0, 2 * one) - one;
    w[W_T2] = one + $urandom_range(0, one);
    w[W_XI] = $urandom_range(0, one);
    w[W_K1] = $urandom_range(0, one / 2) - one / 4;
    w[W_K2] = $urandom_range(0, one / 8) - one / 16;
    w[W_P1] = $urandom_range(0, one / 64) - one / 128;
    w[W_P2] = $urandom_range(0, one / 64) - one / 128;
    w[W_FX] = $urandom_range(100, 600) * one;
    w[W_FY] = $urandom_range(100, 600) * one;
    w[W_CX] = $urandom_range(100, 900) * one;
    w[W_CY] = $urandom_range(100, 700) * one;
    w[W_SIZE] = {16'($urandom_range(200, 4200)), 16'($urandom_range(200, 4200))};
    if (noisy) w[$urandom_range(0, WORDS_PER_CAM - 1)] = $urandom;
    for (int i = 0; i < WORDS_PER_CAM; i++) load_word(cam, i, w[i]);
  endtask

  task automatic test_directed();
    for (int c = 0; c < MAX_CAMERAS; c++) load_camera(c, 1'b0);
    project_px(12'd0, 12'd0);
    project_px(12'hfff, 12'hfff);
    project_px(12'd512, 12'd512);
    project_px(12'd0, 12'hfff);
    project_px(12'hfff, 12'd0);
    // degenerate camera: points behind
    load_word(0, W_XI, -(1 << FRAC_BITS));
    load_word(0, 6, 0);
    load_word(0, 7, 0);
    load_word(0, 8, 0);
    load_word(0, W_T2, 0);
    project_px(12'd512, 12'd512);
    load_word(0, 8, 1 << FRAC_BITS);
    project_px(12'd100, 12'd900);
    load_word(3, 0, 32'sh7fffffff);
    load_word(3, 1, 32'sh80000000);
    project_px(12'd300, 12'd3000);
    // bad load: word index out of range
    load_word(1, 31, $urandom);
    load_word(2, 22, $urandom);
    project_px(12'd700, 12'd200);
    drain();
  endtask

  task automatic test_registers();
    write_reg(CFG_VIEW_WIDTH, 31'd1);
    write_reg(CFG_VIEW_HEIGHT, 31'd4096);
    write_reg(CFG_GROUND_SCALE, 31'h7fffffff);
    write_reg(CFG_ACTIVE_CAMERAS, 31'd1);
    project_px(12'd0, 12'hfff);
    project_px(12'hfff, 12'd0);
    drain();
    write_reg(CFG_VIEW_WIDTH, 31'd4096);
    write_reg(CFG_VIEW_HEIGHT, 31'd1);
    write_reg(CFG_GROUND_SCALE, 31'd1);
    write_reg(CFG_ACTIVE_CAMERAS, 31'd0);
    project_px(12'd10, 12'd10);
    drain();
    write_reg(CFG_ACTIVE_CAMERAS, 31'd7);
    write_reg(CFG_GROUND_SCALE, 31'd20972);
    write_reg(CFG_VIEW_WIDTH, 31'd1024);
    write_reg(CFG_VIEW_HEIGHT, 31'd1024);
    project_px(12'd400, 12'd600);
    drain();
  endtask

  task automatic test_random();
    for (int n = 0; n < 25; n++) begin
      if (n == 0) load_camera($urandom_range(0, MAX_CAMERAS - 1), $urandom_range(0, 3) == 0);
      if (n == 8) begin
        drain();
        write_reg(CFG_ACTIVE_CAMERAS, 31'($urandom_range(1, 4)));
        write_reg(CFG_GROUND_SCALE, 31'($urandom_range(5000, 80000)));
      end
      if (n == 14) hold_req++;
      if (n == 20) drain();
      if ($urandom_range(0, 9) == 0)
        load_word($urandom_range(0, 3), $urandom_range(0, 31), $urandom);
      else if ($urandom_range(0, 3) == 0)
        project_px(12'($urandom), 12'($urandom));
      else
        project_px(12'($urandom_range(0, 1023)), 12'($urandom_range(0, 1023)));
    end
    drain();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= 0;
      hold_seen    <= 0;
    end else if (hold_req != hold_seen) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= 2000;
      hold_seen    <= hold_req;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 150) == 0) hold_cycles <= $urandom_range(10, 80);
    end
  end

  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result cam %0d", got.cam_index));
      end else begin
        want = pending_results.pop_front();
        if (got.cam_index != want.cam_index)
          report_mismatch($sformatf("cam_index %0d want %0d", got.cam_index, want.cam_index));
        if (got.source_x != want.source_x)
          report_mismatch($sformatf("source_x %0d want %0d", got.source_x, want.source_x));
        if (got.source_y != want.source_y)
          report_mismatch($sformatf("source_y %0d want %0d", got.source_y, want.source_y));
        if (got.hit != want.hit)
          report_mismatch($sformatf("hit %0b want %0b", got.hit, want.hit));
        if (got.near_axis != want.near_axis)
          report_mismatch($sformatf("near_axis %0b want %0b", got.near_axis, want.near_axis));
        if (got.last_camera != want.last_camera)
          report_mismatch($sformatf("last_camera %0b want %0b",
                                    got.last_camera, want.last_camera));
      end
    end
  end

  initial begin
    n_errors      = 0;
    hold_req      = 0;
    view_w        = 13'd1024;
    view_h        = 13'd1024;
    scale_q       = 31'd20972;
    cam_count     = 3'd4;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_VIEW_WIDTH;
    cfg_data_i    = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_registers();
    test_random();
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
